>>> src/bse_pkg.sv
// Package for the bit set engine: constants, operation codes and item types.
// No dependencies; every other file of the block imports it.

package bse_pkg;

  // Store geometry.
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned NWORDS    = 32;
  localparam int unsigned WORD_AW   = 5;

  // Largest capacity in use, in bit positions.
  localparam logic [10:0] CAP_MAX = 11'd1024;

  // Operation codes carried in the func field.
  typedef enum logic [3:0] {
    FN_ADD       = 4'd0,
    FN_REMOVE    = 4'd1,
    FN_TEST      = 4'd2,
    FN_MOVE      = 4'd3,
    FN_CLEAR     = 4'd4,
    FN_INVERT    = 4'd5,
    FN_NEXT      = 4'd6,
    FN_COUNT     = 4'd7,
    FN_EMPTY     = 4'd8,
    FN_OR_WORD   = 4'd9,
    FN_ANDNOT    = 4'd10,
    FN_CMP_WORD  = 4'd11
  } func_e;

  // One input item.
  typedef struct packed {
    logic [3:0]  func;
    logic [10:0] bit_index;
    logic [9:0]  target_index;
    logic [4:0]  word_index;
    logic [31:0] word_data;
  } bse_in_t;

  // One result item.
  typedef struct packed {
    logic        flag;
    logic        found;
    logic [9:0]  found_index;
    logic [10:0] member_count;
    logic        error;
  } bse_out_t;

endpackage

>>> src/bse_if.sv
// Valid/ready channel interfaces for the bit set engine.
// Depends on bse_pkg for the payload types.

interface bse_in_if import bse_pkg::*; ();
  logic    valid;
  logic    ready;
  bse_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bse_out_if import bse_pkg::*; ();
  logic     valid;
  logic     ready;
  bse_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/bit_set_engine_unit.sv
// Bit set engine: a 1024-bit set held in a 32 x 32 synchronous word memory.
// Clear, unknown codes, next at capacity and any error go straight to done; add, remove, test
// and word operations read one word and write back any change; move reads source and target,
// then writes target and, if needed, source; next, count, empty and invert walk one memory word per cycle.
// Next item is taken once the previous one has moved to the output register.
// Reset clears the per-word valid bits (empty set) and sets capacity to 1024; a capacity
// write reads the new last word and trims it on the next cycle, during which no item is taken.

module bit_set_engine_unit import bse_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [10:0]  cfg_wdata_i,
  bse_in_if.sink       in_i,
  bse_out_if.source    out_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_READ2  = 7'b0000100,
    S_WRSRC  = 7'b0001000,
    S_WALK   = 7'b0010000,
    S_TRIM   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  // Clamp a written capacity into the range 1 to 1024.
  function automatic logic [10:0] eff_cap(input logic [10:0] v);
    logic [10:0] c;
    c = v;
    if (v == 11'd0) c = 11'd1;
    if (v > CAP_MAX) c = CAP_MAX;
    return c;
  endfunction

  // Bits of word w that lie below capacity, given capacity minus one.
  function automatic logic [31:0] live_mask(input logic [4:0] w, input logic [9:0] cm1);
    logic [31:0] m;
    if (w < cm1[9:5]) m = '1;
    else if (w == cm1[9:5]) m = 32'hffff_ffff >> (5'd31 - cm1[4:0]);
    else m = '0;
    return m;
  endfunction

  function automatic logic [5:0] popcount(input logic [31:0] w);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) n = n + {5'd0, w[i]};
    return n;
  endfunction

  function automatic logic [4:0] lowest_set(input logic [31:0] w);
    logic [4:0] k;
    k = '0;
    for (int i = 31; i >= 0; i--) begin
      if (w[i]) k = 5'(i);
    end
    return k;
  endfunction

  state_e             state_q, state_d;
  logic [10:0]        cap_q, cap_d;
  logic [NWORDS-1:0]  vld_q, vld_d;
  bse_in_t            op_q, op_d;
  bse_out_t           res_q, res_d;
  bse_out_t           out_q;
  logic               out_valid_q;
  logic [31:0]        save_q, save_d;
  logic [5:0]         rp_q, rp_d;
  logic [4:0]         dw_q, dw_d;

  // Memory and its ports.
  logic [31:0]        mem [NWORDS];
  logic               mem_re, mem_we;
  logic [4:0]         mem_raddr, mem_waddr;
  logic [31:0]        mem_wdata;
  logic [31:0]        rd_word_q;
  logic               rd_vld_q;

  // Derived values.
  logic [9:0]         cap_m1;
  logic [5:0]         nw;
  logic [10:0]        cap_new, cap_new_m1;
  logic [31:0]        rd_data, bit_msk, tgt_msk, wd_live, walk_live, nx_word, mv_word;
  logic               mv_src, in_rdy, out_free, accept;

  assign cap_m1     = 10'(cap_q - 11'd1);
  assign nw         = {1'b0, cap_m1[9:5]} + 6'd1;
  assign cap_new    = eff_cap(cfg_wdata_i);
  assign cap_new_m1 = cap_new - 11'd1;

  // A word never written since it was last invalidated reads as zero.
  assign rd_data   = rd_vld_q ? rd_word_q : '0;
  assign bit_msk   = 32'd1 << op_q.bit_index[4:0];
  assign tgt_msk   = 32'd1 << op_q.target_index[4:0];
  assign wd_live   = op_q.word_data & live_mask(op_q.word_index, cap_m1);
  assign walk_live = live_mask(dw_q, cap_m1);
  assign nx_word   = (dw_q == op_q.bit_index[9:5])
                   ? (rd_data & (32'hffff_ffff << op_q.bit_index[4:0])) : rd_data;

  // Move: set the target to the source bit, then clear the source if it was set.
  always_comb begin
    mv_src  = save_q[op_q.bit_index[4:0]];
    mv_word = mv_src ? (rd_data | tgt_msk) : (rd_data & ~tgt_msk);
    if (mv_src && (op_q.bit_index[9:5] == op_q.target_index[9:5])) begin
      mv_word = mv_word & ~bit_msk;
    end
  end

  assign in_rdy   = (state_q == S_IDLE) && !cfg_we_i;
  assign accept   = in_i.valid && in_rdy;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready  = in_rdy;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Sequencer: read, modify and write back the word memory.
  always_comb begin
    state_d   = state_q;
    cap_d     = cap_q;
    vld_d     = vld_q;
    op_d      = op_q;
    res_d     = res_q;
    save_d    = save_q;
    rp_d      = rp_q;
    dw_d      = dw_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          // Drop whole words beyond the new capacity, then trim the last one.
          cap_d = cap_new;
          for (int i = 0; i < int'(NWORDS); i++) begin
            if (5'(i) > cap_new_m1[9:5]) vld_d[i] = 1'b0;
          end
          mem_re    = 1'b1;
          mem_raddr = cap_new_m1[9:5];
          dw_d      = cap_new_m1[9:5];
          state_d   = S_TRIM;
        end else if (accept) begin
          op_d  = in_i.data;
          res_d = '0;
          case (in_i.data.func)
            FN_ADD, FN_REMOVE, FN_TEST: begin
              if (in_i.data.bit_index >= cap_q) begin
                res_d.error = 1'b1;
                state_d     = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_i.data.bit_index[9:5];
                state_d   = S_READ;
              end
            end
            FN_MOVE: begin
              if ((in_i.data.bit_index >= cap_q)
                  || ({1'b0, in_i.data.target_index} >= cap_q)) begin
                res_d.error = 1'b1;
                state_d     = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_i.data.bit_index[9:5];
                state_d   = S_READ;
              end
            end
            FN_CLEAR: begin
              // Words beyond capacity are already zero.
              vld_d   = '0;
              state_d = S_DONE;
            end
            FN_INVERT, FN_COUNT, FN_EMPTY: begin
              res_d.flag = (in_i.data.func == FN_EMPTY);
              mem_re     = 1'b1;
              mem_raddr  = '0;
              dw_d       = '0;
              rp_d       = 6'd1;
              state_d    = S_WALK;
            end
            FN_NEXT: begin
              if (in_i.data.bit_index > cap_q) begin
                res_d.error = 1'b1;
                state_d     = S_DONE;
              end else if (in_i.data.bit_index == cap_q) begin
                state_d = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_i.data.bit_index[9:5];
                dw_d      = in_i.data.bit_index[9:5];
                rp_d      = {1'b0, in_i.data.bit_index[9:5]} + 6'd1;
                state_d   = S_WALK;
              end
            end
            FN_OR_WORD, FN_ANDNOT, FN_CMP_WORD: begin
              if ({1'b0, in_i.data.word_index} >= nw) begin
                res_d.error = 1'b1;
                state_d     = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_i.data.word_index;
                state_d   = S_READ;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        state_d = S_DONE;
        case (op_q.func)
          FN_ADD: begin
            mem_we    = 1'b1;
            mem_waddr = op_q.bit_index[9:5];
            mem_wdata = rd_data | bit_msk;
          end
          FN_REMOVE: begin
            mem_we    = 1'b1;
            mem_waddr = op_q.bit_index[9:5];
            mem_wdata = rd_data & ~bit_msk;
          end
          FN_TEST: begin
            res_d.flag = rd_data[op_q.bit_index[4:0]];
          end
          FN_MOVE: begin
            // Keep the source word and fetch the target word.
            save_d    = rd_data;
            mem_re    = 1'b1;
            mem_raddr = op_q.target_index[9:5];
            state_d   = S_READ2;
          end
          FN_OR_WORD: begin
            mem_we    = 1'b1;
            mem_waddr = op_q.word_index;
            mem_wdata = rd_data | wd_live;
          end
          FN_ANDNOT: begin
            mem_we    = 1'b1;
            mem_waddr = op_q.word_index;
            mem_wdata = rd_data & ~wd_live;
          end
          FN_CMP_WORD: begin
            res_d.flag = (rd_data == wd_live);
          end
          default: begin
          end
        endcase
      end

      S_READ2: begin
        mem_we    = 1'b1;
        mem_waddr = op_q.target_index[9:5];
        mem_wdata = mv_word;
        if (mv_src && (op_q.bit_index[9:5] != op_q.target_index[9:5])) begin
          state_d = S_WRSRC;
        end else begin
          state_d = S_DONE;
        end
      end

      S_WRSRC: begin
        mem_we    = 1'b1;
        mem_waddr = op_q.bit_index[9:5];
        mem_wdata = save_q & ~bit_msk;
        state_d   = S_DONE;
      end

      S_WALK: begin
        // Word dw_q is on the read port; the next read is issued alongside.
        case (op_q.func)
          FN_INVERT: begin
            mem_we    = 1'b1;
            mem_waddr = dw_q;
            mem_wdata = rd_data ^ walk_live;
          end
          FN_COUNT: begin
            res_d.member_count = res_q.member_count + {5'd0, popcount(rd_data)};
          end
          FN_EMPTY: begin
            if (rd_data != '0) res_d.flag = 1'b0;
          end
          FN_NEXT: begin
            if (!res_q.found && (nx_word != '0)) begin
              res_d.found       = 1'b1;
              res_d.found_index = {dw_q, lowest_set(nx_word)};
            end
          end
          default: begin
          end
        endcase
        if (rp_q < nw) begin
          mem_re    = 1'b1;
          mem_raddr = rp_q[4:0];
          dw_d      = rp_q[4:0];
          rp_d      = rp_q + 6'd1;
        end else begin
          state_d = S_DONE;
        end
      end

      S_TRIM: begin
        mem_we    = 1'b1;
        mem_waddr = dw_q;
        mem_wdata = rd_data & walk_live;
        state_d   = S_IDLE;
        if (cfg_we_i) begin
          // A further write: trim this word to both capacities, then fetch the new last word.
          cap_d     = cap_new;
          mem_wdata = rd_data & walk_live & live_mask(dw_q, cap_new_m1[9:0]);
          for (int i = 0; i < int'(NWORDS); i++) begin
            if (5'(i) > cap_new_m1[9:5]) vld_d[i] = 1'b0;
          end
          if (cap_new_m1[9:5] != dw_q) begin
            mem_re    = 1'b1;
            mem_raddr = cap_new_m1[9:5];
            dw_d      = cap_new_m1[9:5];
            state_d   = S_TRIM;
          end
        end
      end

      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A written word becomes valid.
    if (mem_we) vld_d[mem_waddr] = 1'b1;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_MAX;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      vld_q   <= vld_d;
      if (mem_re) rd_vld_q <= vld_q[mem_raddr];
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    res_q  <= res_d;
    save_q <= save_d;
    rp_q   <= rp_d;
    dw_q   <= dw_d;
    if (state_q == S_DONE && out_free) out_q <= res_q;
  end

  // Word memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_word_q <= mem[mem_raddr];
  end

  // The sequence never reads and writes the same word in one cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("memory read and write to the same word in one cycle");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != 11'd0) && (cap_q <= CAP_MAX))
    else $error("effective capacity out of range");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (res_q.member_count <= cap_q))
    else $error("member count exceeds capacity");

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && res_q.found) |-> ({1'b0, res_q.found_index} < cap_q))
    else $error("found index at or beyond capacity");

endmodule
